/* rtl/lsbx_pkg.sv */
`default_nettype none
package lsbx_pkg;

  // Fixed layout of the stream
  localparam int unsigned HEADER_BYTES = 54;
  localparam int unsigned MAGIC_MAX    = 8;

  localparam logic [5:0] HEADER_LAST = 6'(HEADER_BYTES);
  localparam logic [3:0] MAGIC_CAP   = 4'(MAGIC_MAX);
  localparam logic [63:0] MAGIC_CHARS_RST = 64'h0000_0000_0000_2A23;
  localparam logic [3:0]  MAGIC_LEN_RST   = 4'd2;

  // Configuration register indexes
  localparam logic CFG_MAGIC_LEN   = 1'b0;
  localparam logic CFG_MAGIC_CHARS = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_MAGIC   = 3'd1,
    PH_EXT_LEN = 3'd2,
    PH_EXT     = 3'd3,
    PH_PAY_LEN = 3'd4,
    PH_PAY     = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_EXT       = 2'd0,
    KIND_PAY       = 2'd1,
    KIND_MAGIC_ERR = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_e;

  typedef struct packed {
    phase_e      phase;
    logic [5:0]  header_count;
    logic [4:0]  bit_count;
    logic [31:0] bit_shift;
    logic [3:0]  item_index;
    logic [31:0] remaining;
    logic        magic_bad;
  } decode_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    kind_e      kind;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

/* rtl/lsbx_in_if.sv */
`default_nettype none
interface lsbx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       restart;

  modport source (output valid, output pixel_byte, output restart, input ready);
  modport sink   (input valid, input pixel_byte, input restart, output ready);
endinterface
`default_nettype wire

/* rtl/lsbx_out_if.sv */
`default_nettype none
interface lsbx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface
`default_nettype wire

/* rtl/lsbx_step.sv */
`default_nettype none
module lsbx_step (
  input  lsbx_pkg::decode_t cur_i,
  input  logic [7:0]        pixel_byte_i,
  input  logic              restart_i,
  input  logic [3:0]        magic_len_i,
  input  logic [63:0]       magic_chars_i,
  output lsbx_pkg::decode_t nxt_o,
  output lsbx_pkg::result_t res_o
);
  import lsbx_pkg::*;

  decode_t     st;
  decode_t     nxt;
  result_t     res;
  logic [3:0]  eff_len;
  logic [31:0] sh_val;
  logic [4:0]  cnt;
  logic        is_len;
  logic        done;
  logic        skip;
  logic        bad;
  logic [3:0]  idx_n;
  logic [7:0]  want;
  logic [31:0] len;
  logic [31:0] rem;

  // Saturate the magic length
  assign eff_len = (magic_len_i > MAGIC_CAP) ? MAGIC_CAP : magic_len_i;

  // Advance the decode by one file word
  always_comb begin
    st = cur_i;
    if (restart_i) begin
      st = '0;
      st.phase = PH_HEADER;
    end
    // Select the expected magic character
    want   = magic_chars_i[{st.item_index[2:0], 3'b000} +: 8];
    nxt    = st;
    res    = '0;
    res.kind = KIND_EXT;
    skip   = 1'b0;
    sh_val = '0;
    cnt    = '0;
    is_len = 1'b0;
    done   = 1'b0;
    bad    = 1'b0;
    idx_n  = '0;
    len    = '0;
    rem    = st.remaining - 32'd1;

    // Drop header words
    if (st.phase == PH_HEADER) begin
      if (st.header_count < HEADER_LAST) begin
        nxt.header_count = st.header_count + 6'd1;
        skip = 1'b1;
      end else begin
        nxt.phase = PH_MAGIC;
      end
    end

    if (!skip) begin
      if (nxt.phase == PH_MAGIC && nxt.item_index >= eff_len) begin
        nxt.phase = PH_EXT_LEN;
      end
      if (nxt.phase != PH_DONE && nxt.phase != PH_ERROR) begin
        // Gather one data bit, MSB first
        sh_val = {nxt.bit_shift[30:0], pixel_byte_i[0]};
        cnt    = nxt.bit_count + 5'd1;
        is_len = (nxt.phase == PH_EXT_LEN) || (nxt.phase == PH_PAY_LEN);
        done   = is_len ? (cnt == 5'd0) : (cnt == 5'd8);
        nxt.bit_shift = sh_val;
        nxt.bit_count = cnt;
        len = sh_val[31] ? 32'd0 : sh_val;
        if (done) begin
          nxt.bit_shift = '0;
          nxt.bit_count = '0;
          case (nxt.phase)
            PH_MAGIC: begin
              bad = nxt.magic_bad | (sh_val[7:0] != want);
              nxt.magic_bad = bad;
              idx_n = nxt.item_index + 4'd1;
              nxt.item_index = idx_n;
              if (idx_n >= eff_len) begin
                if (bad) begin
                  nxt.phase = PH_ERROR;
                  res.valid = 1'b1;
                  res.kind  = KIND_MAGIC_ERR;
                  res.last  = 1'b1;
                end else begin
                  nxt.phase = PH_EXT_LEN;
                end
              end
            end
            PH_EXT_LEN: begin
              nxt.remaining = len;
              nxt.phase = (len != 32'd0) ? PH_EXT : PH_PAY_LEN;
            end
            PH_EXT: begin
              nxt.remaining = rem;
              if (rem == 32'd0) begin
                nxt.phase = PH_PAY_LEN;
              end
              res.valid    = 1'b1;
              res.out_byte = sh_val[7:0];
              res.kind     = KIND_EXT;
            end
            PH_PAY_LEN: begin
              nxt.remaining = len;
              if (len == 32'd0) begin
                nxt.phase = PH_DONE;
                res.valid = 1'b1;
                res.kind  = KIND_EMPTY;
                res.last  = 1'b1;
              end else begin
                nxt.phase = PH_PAY;
              end
            end
            PH_PAY: begin
              nxt.remaining = rem;
              res.valid     = 1'b1;
              res.out_byte  = sh_val[7:0];
              res.kind      = KIND_PAY;
              if (rem == 32'd0) begin
                nxt.phase = PH_DONE;
                res.last  = 1'b1;
              end
            end
            default: begin
              nxt.phase = nxt.phase;
            end
          endcase
        end
      end
    end
  end

  assign nxt_o = nxt;
  assign res_o = res;

endmodule
`default_nettype wire

/* rtl/lsb_stego_payload_extractor.sv */
`default_nettype none
// Channel   Dir  Word fields                Notes
// pix_in    in   pixel_byte[7:0], restart   one file byte per word
// res_out   out  out_byte[7:0], kind, last  zero or one word per input word
// cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i  0: magic length, 1: magic chars
//
// One input word per cycle: the decode state registers are updated in the
// cycle a word is taken, and any result lands in the output register.
// The output register is the only buffer: input is taken whenever it is empty
// or being emptied in the same cycle, so a stalled sink stalls the input.
// Reset (async, active low) clears the decode to the header skip and loads
// the default magic ("#*", two characters).
module lsb_stego_payload_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsbx_in_if.sink     pix_in,
  lsbx_out_if.source  res_out,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);
  import lsbx_pkg::*;

  decode_t     decode_q, decode_d;
  result_t     step_res;
  result_t     res_q;
  logic [3:0]  magic_len_q;
  logic [63:0] magic_chars_q;
  logic        accept;

  // Take a word when the output register is free or being drained
  assign pix_in.ready = !res_q.valid || res_out.ready;
  assign accept       = pix_in.valid && pix_in.ready;

  lsbx_step u_step (
    .cur_i         (decode_q),
    .pixel_byte_i  (pix_in.pixel_byte),
    .restart_i     (pix_in.restart),
    .magic_len_i   (magic_len_q),
    .magic_chars_i (magic_chars_q),
    .nxt_o         (decode_d),
    .res_o         (step_res)
  );

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_len_q   <= MAGIC_LEN_RST;
      magic_chars_q <= MAGIC_CHARS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC_LEN:   magic_len_q   <= cfg_wdata_i[3:0];
        CFG_MAGIC_CHARS: magic_chars_q <= cfg_wdata_i;
        default:         magic_len_q   <= magic_len_q;
      endcase
    end
  end

  // Advance decode state on each accepted word; all zero is the header skip
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_q <= '0;
    end else if (accept) begin
      decode_q <= decode_d;
    end
  end

  // Load or drain the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (accept && step_res.valid) begin
      res_q <= step_res;
    end else if (res_out.ready) begin
      res_q.valid <= 1'b0;
    end
  end

  assign res_out.valid    = res_q.valid;
  assign res_out.out_byte = res_q.out_byte;
  assign res_out.kind     = res_q.kind;
  assign res_out.last     = res_q.last;

endmodule
`default_nettype wire

/* dv/tb_lsb_stego_payload_extractor.sv */
module tb_lsb_stego_payload_extractor;
  import lsbx_pkg::*;

  localparam int ITEMS       = 1650;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [63:0] cfg_wdata_i;

  lsbx_in_if  pix ();
  lsbx_out_if res ();

  lsb_stego_payload_extractor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_in      (pix),
    .res_out     (res),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Decoder state and register copies
  phase_e      dec_phase;
  logic [5:0]  hdr_cnt;
  logic [4:0]  bit_cnt;
  logic [31:0] shift_reg;
  logic [3:0]  magic_idx;
  logic [31:0] bytes_left;
  logic        magic_bad;
  logic [3:0]  cfg_magic_len;
  logic [63:0] cfg_magic_chars;

  result_t     expected_words[$];
  logic        stream_bits[$];
  int          mismatches      = 0;
  int          items_sent      = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int          hold_left       = 0;
  int          quiet_cycles    = 0;

  function automatic void clear_decode_state();
    dec_phase  = PH_HEADER;
    hdr_cnt    = '0;
    bit_cnt    = '0;
    shift_reg  = '0;
    magic_idx  = '0;
    bytes_left = '0;
    magic_bad  = 1'b0;
  endfunction

  function automatic logic [3:0] eff_magic();
    return (cfg_magic_len > MAGIC_CAP) ? MAGIC_CAP : cfg_magic_len;
  endfunction

  function automatic result_t make_word(input logic [7:0] b, input kind_e k, input logic lst);
    result_t r;
    r.valid    = 1'b1;
    r.out_byte = b;
    r.kind     = k;
    r.last     = lst;
    return r;
  endfunction

  // Advance the decoder by one file byte; valid is set when a word results
  function automatic result_t decode_byte(input logic [7:0] pbyte, input logic rs);
    result_t     r;
    logic [31:0] word;
    logic [7:0]  want;
    r = '0;
    if (rs) clear_decode_state();
    if (dec_phase == PH_HEADER) begin
      if (hdr_cnt < HEADER_LAST) begin
        hdr_cnt = hdr_cnt + 1'b1;
        return r;
      end
      dec_phase = PH_MAGIC;
    end
    if (dec_phase == PH_MAGIC && magic_idx >= eff_magic()) dec_phase = PH_EXT_LEN;
    if (dec_phase == PH_DONE || dec_phase == PH_ERROR) return r;

    // gather one bit, MSB first
    shift_reg = {shift_reg[30:0], pbyte[0]};
    bit_cnt   = bit_cnt + 1'b1;
    if (dec_phase inside {PH_EXT_LEN, PH_PAY_LEN}) begin
      if (bit_cnt != 5'd0) return r;
    end else if (bit_cnt != 5'd8) begin
      return r;
    end
    word      = shift_reg;
    shift_reg = '0;
    bit_cnt   = '0;

    case (dec_phase)
      PH_MAGIC: begin
        want = cfg_magic_chars[magic_idx[2:0] * 8 +: 8];
        if (word[7:0] != want) magic_bad = 1'b1;
        magic_idx = magic_idx + 1'b1;
        if (magic_idx >= eff_magic()) begin
          if (magic_bad) begin
            dec_phase = PH_ERROR;
            r = make_word(8'h00, KIND_MAGIC_ERR, 1'b1);
          end else begin
            dec_phase = PH_EXT_LEN;
          end
        end
      end
      PH_EXT_LEN: begin
        // a length with the sign bit set counts as zero
        if (word[31]) word = '0;
        bytes_left = word;
        dec_phase  = (word != 0) ? PH_EXT : PH_PAY_LEN;
      end
      PH_EXT: begin
        bytes_left = bytes_left - 1;
        if (bytes_left == 0) dec_phase = PH_PAY_LEN;
        r = make_word(word[7:0], KIND_EXT, 1'b0);
      end
      PH_PAY_LEN: begin
        if (word[31]) word = '0;
        bytes_left = word;
        if (word == 0) begin
          dec_phase = PH_DONE;
          r = make_word(8'h00, KIND_EMPTY, 1'b1);
        end else begin
          dec_phase = PH_PAY;
        end
      end
      PH_PAY: begin
        bytes_left = bytes_left - 1;
        if (bytes_left == 0) dec_phase = PH_DONE;
        r = make_word(word[7:0], KIND_PAY, bytes_left == 0);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one file byte, idling first at the configured rate
  task automatic send_pixel(input logic [7:0] b, input logic rs);
    result_t step;
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid      <= 1'b1;
    pix.pixel_byte <= b;
    pix.restart    <= rs;
    do @(posedge clk_i); while (!pix.ready);
    items_sent++;
    step = decode_byte(b, rs);
    if (step.valid) begin
      expected_words.push_back(step);
    end
  endtask

  task automatic push_field(input logic [31:0] v, input int nbits);
    for (int i = nbits - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endtask

  task automatic keep_bits(input int n);
    while (stream_bits.size() > n) void'(stream_bits.pop_back());
  endtask

  // Build the data bits of one file: magic, extension and payload sections
  task automatic queue_file(input int n_magic, input logic [63:0] magic,
                            input logic [31:0] ext_len, input int n_ext,
                            input logic [31:0] pay_len, input int n_pay);
    stream_bits.delete();
    for (int k = 0; k < n_magic; k++) push_field(32'(magic[8 * k +: 8]), 8);
    push_field(ext_len, 32);
    for (int k = 0; k < n_ext; k++) push_field($urandom_range(255), 8);
    push_field(pay_len, 32);
    for (int k = 0; k < n_pay; k++) push_field($urandom_range(255), 8);
  endtask

  // Send hdr_n header bytes, then one byte per queued data bit
  task automatic send_file(input logic rs_first, input int hdr_n);
    for (int i = 0; i < hdr_n; i++) send_pixel(8'($urandom), rs_first && i == 0);
    while (stream_bits.size() != 0)
      send_pixel({7'($urandom_range(127)), stream_bits.pop_front()}, 1'b0);
  endtask

  // Drop the input and wait until every expected word has left the block
  task automatic settle_block();
    pix.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Settle, then switch the idling rates of both sides
  task automatic set_phase(input logic [1:0] p);
    int unsigned idle_by_phase[4];
    int unsigned stall_by_phase[4];
    idle_by_phase  = '{0, 77, 0, 15};
    stall_by_phase = '{0, 0, 77, 15};
    settle_block();
    send_idle_pct  = idle_by_phase[p];
    recv_stall_pct = stall_by_phase[p];
  endtask

  task automatic write_magic(input logic [3:0] len, input logic [63:0] chars);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MAGIC_LEN;
    cfg_wdata_i <= {28'($urandom), 32'($urandom), len};
    @(posedge clk_i);
    cfg_magic_len = len;
    cfg_idx_i   <= CFG_MAGIC_CHARS;
    cfg_wdata_i <= chars;
    @(posedge clk_i);
    cfg_magic_chars = chars;
    cfg_we_i    <= 1'b0;
  endtask

  task automatic test_default_magic();
    // decode straight out of reset, no restart flag on byte zero
    queue_file(int'(eff_magic()), cfg_magic_chars, 32'd3, 3, 32'd4, 0);
    push_field(32'h00, 8);
    push_field(32'hFF, 8);
    push_field(32'h5A, 8);
    push_field(32'hA5, 8);
    send_file(1'b0, HEADER_BYTES);
    // bytes after the last payload word are dropped
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFE, 1'b0);
    send_pixel(8'h01, 1'b0);
  endtask

  task automatic test_magic_mismatch();
    logic [63:0] m;
    // bad last character, then a bad first one with the rest intact;
    // a few trailing bits after the magic must be dropped
    m = cfg_magic_chars;
    m[15:8] ^= 8'h80;
    queue_file(int'(eff_magic()), m, 32'd1, 1, 32'd2, 2);
    keep_bits(8 * eff_magic() + 16);
    send_file(1'b1, HEADER_BYTES);
    m = cfg_magic_chars;
    m[0] ^= 1'b1;
    queue_file(int'(eff_magic()), m, 32'd1, 1, 32'd2, 2);
    keep_bits(8 * eff_magic() + 16);
    send_file(1'b1, HEADER_BYTES);
  endtask

  task automatic test_lengths();
    // empty payload, with trailing bits that must be dropped
    queue_file(int'(eff_magic()), cfg_magic_chars, 32'd0, 0, 32'd0, 0);
    push_field($urandom, 16);
    send_file(1'b1, HEADER_BYTES);
    // negative extension length, single payload byte
    queue_file(int'(eff_magic()), cfg_magic_chars, 32'h8000_0005, 0, 32'd1, 1);
    send_file(1'b1, HEADER_BYTES);
    // both lengths negative
    queue_file(int'(eff_magic()), cfg_magic_chars, 32'hFFFF_FFFF, 0, 32'h8000_0000, 0);
    send_file(1'b1, HEADER_BYTES);
  endtask

  task automatic test_magic_config();
    // no magic at all
    settle_block();
    write_magic(4'd0, 64'd0);
    queue_file(0, 64'd0, 32'd1, 1, 32'd1, 1);
    send_file(1'b1, HEADER_BYTES);
    // one all-zero character
    settle_block();
    write_magic(4'd1, 64'd0);
    queue_file(1, 64'd0, 32'd0, 0, 32'd1, 1);
    send_file(1'b1, HEADER_BYTES);
    // length above the cap saturates to eight characters
    settle_block();
    write_magic(4'hF, '1);
    queue_file(MAGIC_MAX, '1, 32'd1, 1, 32'd1, 1);
    send_file(1'b1, HEADER_BYTES);
    settle_block();
    write_magic(MAGIC_LEN_RST, MAGIC_CHARS_RST);
  endtask

  task automatic test_restart_mid_decode();
    // restart inside the header, the magic, the extension and a long payload
    queue_file(int'(eff_magic()), cfg_magic_chars, 32'd2, 2, 32'd3, 3);
    stream_bits.delete();
    send_file(1'b1, 20);
    queue_file(int'(eff_magic()), cfg_magic_chars, 32'd2, 2, 32'd3, 3);
    keep_bits(10);
    send_file(1'b1, HEADER_BYTES);
    queue_file(int'(eff_magic()), cfg_magic_chars, 32'd2, 2, 32'd3, 3);
    keep_bits(8 * eff_magic() + 32 + 12);
    send_file(1'b1, HEADER_BYTES);
    queue_file(int'(eff_magic()), cfg_magic_chars, 32'd0, 0, 32'h7FFF_FFFF, 5);
    send_file(1'b1, HEADER_BYTES);
  endtask

  task automatic test_backpressure();
    // hold the sink while a word-heavy file keeps arriving
    hold_left = HOLD_CYCLES;
    queue_file(int'(eff_magic()), cfg_magic_chars, 32'd0, 0, 32'd8, 8);
    send_file(1'b1, HEADER_BYTES);
  endtask

  task automatic random_file();
    int unsigned style, eff, k, n_ext, n_pay, hdr;
    logic [63:0] magic;
    logic [31:0] ext_len, pay_len;
    eff     = 32'(eff_magic());
    magic   = cfg_magic_chars;
    n_ext   = $urandom_range(3);
    n_pay   = $urandom_range(1, 8);
    ext_len = n_ext;
    pay_len = n_pay;
    hdr     = HEADER_BYTES;
    style   = $urandom_range(99);
    // mostly clean files; the rest carry a fault
    if (style < 6 && eff != 0) begin
      k = $urandom_range(eff - 1);
      magic[8 * k + $urandom_range(7)] ^= 1'b1;
    end else if (style < 10) begin
      ext_len = {1'b1, 31'($urandom)};
      n_ext   = 0;
    end else if (style < 14) begin
      pay_len = (style < 12) ? 32'd0 : {1'b1, 31'($urandom)};
      n_pay   = 0;
    end
    queue_file(eff, magic, ext_len, n_ext, pay_len, n_pay);
    if (style >= 14 && style < 22) begin
      keep_bits($urandom_range(stream_bits.size() - 1));
    end else if (style >= 22 && style < 24) begin
      hdr = $urandom_range(1, HEADER_BYTES - 1);
      stream_bits.delete();
    end
    send_file(1'b1, hdr);
    repeat ($urandom_range(2)) send_pixel(8'($urandom), 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [1:0] p;
    // random files across the idling phases until the byte budget is spent
    p = 2'd0;
    do begin
      set_phase(p);
      write_magic(4'($urandom_range(1, MAGIC_MAX)), {$urandom, $urandom});
      random_file();
      p = p + 2'd1;
    end while (items_sent < ITEMS);
  endtask

  // Sink ready: long hold first, else random stalls
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk_i) begin : check_words
    result_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: byte %02h kind %0d last %0b",
                   res.out_byte, res.kind, res.last);
      end else begin
        want = expected_words.pop_front();
        if (res.out_byte !== want.out_byte || res.kind !== want.kind ||
            res.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected byte %02h kind %0d last %0b, got %02h %0d %0b",
                     want.out_byte, want.kind, want.last, res.out_byte, res.kind, res.last);
        end
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    pix.valid      <= 1'b0;
    pix.pixel_byte <= 8'h00;
    pix.restart    <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_MAGIC_LEN;
    cfg_wdata_i    <= '0;
    cfg_magic_len   = MAGIC_LEN_RST;
    cfg_magic_chars = MAGIC_CHARS_RST;
    clear_decode_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_magic();
    test_magic_mismatch();
    set_phase(2'd1);
    test_lengths();
    set_phase(2'd2);
    test_restart_mid_decode();
    set_phase(2'd3);
    test_magic_config();
    set_phase(2'd0);
    test_backpressure();
    test_random_traffic();

    settle_block();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* lsb_stego_payload_extractor.f */
rtl/lsbx_pkg.sv
rtl/lsbx_in_if.sv
rtl/lsbx_out_if.sv
rtl/lsbx_step.sv
rtl/lsb_stego_payload_extractor.sv
dv/tb_lsb_stego_payload_extractor.sv
